// File: design/rcs_pkg.sv
package rcs_pkg;
  localparam int unsigned Channels   = 3;
  localparam int unsigned MaxPixels  = 4194304;
  localparam int unsigned CountW     = 23;
  localparam int unsigned SumW       = 30;
  localparam int unsigned SqW        = 54;
  localparam int unsigned SampleW    = 8;
  localparam int unsigned RefW       = 16;
  localparam int unsigned MeanW      = 16;
  localparam int unsigned MseW       = 24;
  // dividends: mean 38 bits (sum<<8), mse 54 bits; one shared divider of 54 bits
  localparam int unsigned DivW       = 54;
  localparam int unsigned DivorW     = 31;
  localparam int unsigned DivCntW    = 6;
  localparam int unsigned ChIdxW     = 2;
  localparam logic [1:0] RegRedIdx   = 2'd0;
  localparam logic [1:0] RegGreenIdx = 2'd1;
  localparam logic [1:0] RegBlueIdx  = 2'd2;

  typedef struct packed {
    logic clear;
    logic add;
  } rcs_lane_ctl_t;
endpackage

// File: design/rcs_lane.sv
module rcs_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcs_pkg::rcs_lane_ctl_t           ctl,
  input  logic [rcs_pkg::SampleW-1:0]      sample,
  input  logic [rcs_pkg::RefW-1:0]         ref_mean,
  output logic [rcs_pkg::SumW-1:0]         sum,
  output logic [rcs_pkg::SqW-1:0]          sq_sum,
  output logic [rcs_pkg::SampleW-1:0]      peak
);
  import rcs_pkg::*;

  logic [SumW-1:0]    sum_r, sum_nxt;
  logic [SqW-1:0]     sq_r, sq_nxt;
  logic [SampleW-1:0] peak_r, peak_nxt;
  logic [RefW-1:0]    fx, diff;
  logic [2*RefW-1:0]  sq;

  always_comb begin
    fx   = {sample, 8'd0};
    diff = (fx >= ref_mean) ? fx - ref_mean : ref_mean - fx;
    sq   = diff * diff;
    sum_nxt  = sum_r;
    sq_nxt   = sq_r;
    peak_nxt = peak_r;
    if (ctl.add) begin
      sum_nxt  = sum_r + SumW'(sample);
      sq_nxt   = sq_r + SqW'(sq);
      peak_nxt = (sample > peak_r) ? sample : peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r  <= '0;
      sq_r   <= '0;
      peak_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
      peak_r <= peak_nxt;
    end
  end

  // totals including the pixel being accepted this cycle
  assign sum    = sum_nxt;
  assign sq_sum = sq_nxt;
  assign peak   = peak_nxt;
endmodule

// File: design/rcs_div.sv
module rcs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rcs_pkg::DivW-1:0]      dividend,
  input  logic [rcs_pkg::DivorW-1:0]    divisor,
  output logic                          busy,
  output logic [rcs_pkg::DivW-1:0]      quotient
);
  import rcs_pkg::*;

  logic [DivW-1:0]    q_r, q_nxt;
  logic [DivorW:0]    rem_r, rem_nxt;
  logic [DivorW-1:0]  d_r;
  logic [DivCntW-1:0] cnt_r;
  logic               busy_r;
  logic [DivorW+1:0]  trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, q_r[DivW-1]} - {2'b00, d_r};
    q_nxt   = {q_r[DivW-2:0], ~trial[DivorW+1]};
    rem_nxt = trial[DivorW+1] ? {rem_r[DivorW-1:0], q_r[DivW-1]} : trial[DivorW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DivCntW'(DivW - 1);
      q_r    <= dividend;
      rem_r  <= '0;
      d_r    <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule

// File: design/rgb_channel_statistics_top.sv
// Per-frame RGB statistics. One pixel transaction per cycle is accepted while
// a frame streams in; three channel lanes accumulate sum, squared error versus
// ref_mean_* and peak. The transaction carrying last_pixel closes the frame:
// the lane totals are latched and the lanes cleared, and a shared 54-bit
// restoring divider then produces six quotients (three means, three MSEs)
// one after another, each by load, 54 steps and write back, so in_stall
// is held high until the result is registered. The result transaction
// then waits in an output register; a closing pixel is held off until that
// result has left. Pixels beyond 4194304 in a frame are dropped. Config
// writes are taken at any time; write them idle.
module rgb_channel_statistics_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_value,
  input  logic [7:0]  in_green_value,
  input  logic [7:0]  in_blue_value,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_mean_red,
  output logic [15:0] out_mean_green,
  output logic [15:0] out_mean_blue,
  output logic [23:0] out_mse_red,
  output logic [23:0] out_mse_green,
  output logic [23:0] out_mse_blue,
  output logic [7:0]  out_peak_red,
  output logic [7:0]  out_peak_green,
  output logic [7:0]  out_peak_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rcs_pkg::*;

  typedef enum logic [1:0] {S_RUN, S_LOAD, S_WAIT, S_OUT} state_t;

  state_t state_r;
  logic [RefW-1:0]    ref_r [Channels];
  logic [SampleW-1:0] samp [Channels];
  logic [SumW-1:0]    sum [Channels];
  logic [SqW-1:0]     sqs [Channels];
  logic [SampleW-1:0] pk [Channels];
  logic [SumW-1:0]    fsum_r [Channels];
  logic [SqW-1:0]     fsq_r [Channels];
  logic [CountW-1:0]  cnt_r, fcnt_r;
  logic [MeanW-1:0]   mean_r [Channels];
  logic [MseW-1:0]    mse_r [Channels];
  logic [SampleW-1:0] peak_r [Channels];
  logic [2:0]         job_r;
  logic               out_valid_r;
  logic               accept, keep, div_start, div_busy;
  logic [DivW-1:0]    dvd, quo;
  logic [DivorW-1:0]  dvs;
  logic [ChIdxW-1:0]  ch;
  rcs_lane_ctl_t      ctl;

  assign in_stall  = (state_r != S_RUN) || out_valid_r && in_last_pixel;
  assign accept    = in_valid && !in_stall;
  assign keep      = cnt_r < CountW'(MaxPixels);
  assign ctl.add   = accept && keep;
  assign ctl.clear = accept && in_last_pixel;
  assign cfg_ready = 1'b1;
  assign samp[0] = in_red_value;
  assign samp[1] = in_green_value;
  assign samp[2] = in_blue_value;

  // lane outputs already include the pixel accepted this cycle
  for (genvar g = 0; g < Channels; g++) begin : g_lane
    rcs_lane u_lane (
      .clk, .rst_n, .ctl, .sample(samp[g]), .ref_mean(ref_r[g]),
      .sum(sum[g]), .sq_sum(sqs[g]), .peak(pk[g])
    );
  end

  // jobs 0..2 mean of channel job, 3..5 mse of channel job-3
  always_comb begin
    ch = (job_r >= 3'd3) ? ChIdxW'(job_r - 3'd3) : ChIdxW'(job_r);
    if (job_r >= 3'd3) begin
      dvd = fsq_r[ch];
      dvs = {fcnt_r, 8'd0};
    end else begin
      dvd = DivW'({fsum_r[ch], 8'd0});
      dvs = DivorW'(fcnt_r);
    end
  end
  assign div_start = (state_r == S_LOAD);

  rcs_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(dvd), .divisor(dvs),
    .busy(div_busy), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      job_r       <= '0;
      for (int i = 0; i < Channels; i++) ref_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegRedIdx:   ref_r[0] <= cfg_data;
          RegGreenIdx: ref_r[1] <= cfg_data;
          RegBlueIdx:  ref_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_RUN: begin
          if (ctl.clear) begin
            for (int i = 0; i < Channels; i++) begin
              fsum_r[i] <= sum[i];
              fsq_r[i]  <= sqs[i];
              peak_r[i] <= pk[i];
            end
            fcnt_r  <= keep ? cnt_r + 1'b1 : cnt_r;
            cnt_r   <= '0;
            job_r   <= '0;
            state_r <= S_LOAD;
          end else if (ctl.add) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LOAD: state_r <= S_WAIT;
        S_WAIT: begin
          if (!div_busy) begin
            if (job_r >= 3'd3) mse_r[ch] <= (fcnt_r == '0) ? '0 : MseW'(quo);
            else mean_r[ch] <= (fcnt_r == '0) ? '0 : MeanW'(quo);
            if (job_r == 3'd5) begin
              state_r <= S_OUT;
            end else begin
              job_r   <= job_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_red   = mean_r[0];
  assign out_mean_green = mean_r[1];
  assign out_mean_blue  = mean_r[2];
  assign out_mse_red    = mse_r[0];
  assign out_mse_green  = mse_r[1];
  assign out_mse_blue   = mse_r[2];
  assign out_peak_red   = peak_r[0];
  assign out_peak_green = peak_r[1];
  assign out_peak_blue  = peak_r[2];

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> in_stall) else $error("accept during divide");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT)) else $error("spurious result");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CountW'(MaxPixels)) else $error("count overrun");
`endif
endmodule

// File: bench/rgb_channel_statistics_top_test.sv
`timescale 1ns / 1ps

module rgb_channel_statistics_top_test;
  import rcs_pkg::*;

  // One frame's worth of statistics, as it leaves the result channel.
  typedef struct {
    logic [15:0] mean [3];
    logic [23:0] mse  [3];
    logic [7:0]  peak [3];
  } frame_stats_t;

  // Scoreboard: mirrors the accumulation, predicts a frame's statistics on
  // the closing pixel and checks results against the oldest prediction.
  class frame_stats_board;
    logic [15:0]  ref_mean [3];
    logic [29:0]  sums     [3];
    logic [53:0]  sq_sums  [3];
    logic [7:0]   peaks    [3];
    logic [22:0]  count;
    frame_stats_t pending_stats [$];
    int           errors;

    function void clear_frame();
      for (int c = 0; c < 3; c++) begin
        sums[c] = '0; sq_sums[c] = '0; peaks[c] = '0;
      end
      count = '0;
    endfunction

    function void reset();
      for (int c = 0; c < 3; c++) ref_mean[c] = '0;
      clear_frame();
      pending_stats.delete();
      errors = 0;
    endfunction

    function void write_ref(logic [1:0] idx, logic [15:0] val);
      if (idx < 3) ref_mean[idx] = val;
    endfunction

    function void note_pixel(logic [7:0] px [3], logic last);
      frame_stats_t st;
      logic [63:0] fx, d;
      if (count < MaxPixels) begin
        for (int c = 0; c < 3; c++) begin
          fx = {48'd0, px[c], 8'd0};
          d = (fx >= ref_mean[c]) ? fx - ref_mean[c] : ref_mean[c] - fx;
          sums[c] = sums[c] + px[c];
          sq_sums[c] = sq_sums[c] + d * d;
          if (px[c] > peaks[c]) peaks[c] = px[c];
        end
        count = count + 1;
      end
      if (!last) return;
      for (int c = 0; c < 3; c++) begin
        logic [63:0] m, e;
        m = 0; e = 0;
        if (count != 0) begin
          m = ({34'd0, sums[c]} << 8) / count;
          e = {10'd0, sq_sums[c]} / ({41'd0, count} << 8);
        end
        st.mean[c] = m[15:0];
        st.mse[c]  = e[23:0];
        st.peak[c] = peaks[c];
      end
      pending_stats.push_back(st);
      clear_frame();
    endfunction

    function void check_result(frame_stats_t got);
      frame_stats_t exp_st;
      string nm [3];
      nm = '{"red", "green", "blue"};
      if (pending_stats.size() == 0) begin
        $error("result transaction with no frame pending");
        errors++;
        return;
      end
      exp_st = pending_stats.pop_front();
      for (int c = 0; c < 3; c++) begin
        if (got.mean[c] !== exp_st.mean[c]) begin
          $error("mean_%s expected %0d got %0d", nm[c], exp_st.mean[c], got.mean[c]);
          errors++;
        end
        if (got.mse[c] !== exp_st.mse[c]) begin
          $error("mse_%s expected %0d got %0d", nm[c], exp_st.mse[c], got.mse[c]);
          errors++;
        end
        if (got.peak[c] !== exp_st.peak[c]) begin
          $error("peak_%s expected %0d got %0d", nm[c], exp_st.peak[c], got.peak[c]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red_value, in_green_value, in_blue_value;
  logic        in_last_pixel;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_mean_red, out_mean_green, out_mean_blue;
  logic [23:0] out_mse_red, out_mse_green, out_mse_blue;
  logic [7:0]  out_peak_red, out_peak_green, out_peak_blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  rgb_channel_statistics_top u_dut (.*);

  frame_stats_board board;

  // Idle rates in percent for the sender and receiver, per phase.
  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A frame end costs divider time plus receiver stalls;
  // 1500 pixels with many short frames stays well below.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3_000_000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall driven at the falling edge, result sampled at
  // the rising edge when the transaction completes.
  initial begin
    frame_stats_t got;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.mean = '{out_mean_red, out_mean_green, out_mean_blue};
        got.mse  = '{out_mse_red, out_mse_green, out_mse_blue};
        got.peak = '{out_peak_red, out_peak_green, out_peak_blue};
        board.check_result(got);
      end
    end
  end

  // Send one pixel transaction; holds it until accepted. Valid stays high
  // afterwards; the next call or an explicit idle drops it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    logic [7:0] px [3];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_red_value   <= r;
    in_green_value <= g;
    in_blue_value  <= b;
    in_last_pixel  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    px = '{r, g, b};
    board.note_pixel(px, last);
    @(negedge clk);
  endtask

  // Wait until every predicted frame has come out, plus divider slack.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_stats.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_ref(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random frame: mostly short, values biased toward the edges sometimes.
  task automatic random_frame(int len);
    logic [7:0] r, g, b;
    for (int i = 0; i < len; i++) begin
      r = $urandom; g = $urandom; b = $urandom;
      if ($urandom_range(9) == 0) r = 8'hFF;
      if ($urandom_range(9) == 0) b = 8'h00;
      send_pixel(r, g, b, i == len - 1);
    end
  endtask

  initial begin
    int len;
    board = new();
    board.reset();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_value = '0; in_green_value = '0; in_blue_value = '0;
    in_last_pixel = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset references, single-pixel frames at the extremes,
    // an all-zero frame (peak starts from zero), then extreme references.
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hAA, 8'h55, 8'h01, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'hFE, 1'b1);
    drain();
    write_cfg(RegRedIdx, 16'hFFFF);    // above nominal range
    write_cfg(RegGreenIdx, 16'hFF00);
    write_cfg(RegBlueIdx, 16'h0000);
    write_cfg(2'd3, 16'h1234);         // out-of-range index, ignored
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) send_pixel(8'hFF, 8'h00, 8'hFF, i == 7);
    drain();

    // Random phases with changing references and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_cfg(RegRedIdx, (ph == 4) ? 16'h0000 : 16'($urandom));
      write_cfg(RegGreenIdx, (ph == 5) ? 16'hFFFF : 16'($urandom_range(16'hFF00)));
      write_cfg(RegBlueIdx, 16'($urandom));
      for (int n = 0; n < 190; n += len) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        random_frame(len);
        // Hold off once until everything predicted has come out.
        if (ph == 2 && n == 0) begin
          in_valid <= 1'b0;
          while (board.pending_stats.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (board.errors == 0 && board.pending_stats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
